@@ sv/frn_pkg.sv @@
// Shared types, microcode encoding and control store of the fraction ratio normalizer.
package frn_pkg;

  // Micro program counter: the control store has eleven steps.
  typedef logic [3:0] upc_t;

  // Datapath operation selected by a control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_AB,
    OP_DIV_STEP,
    OP_SWAP,
    OP_DIV_NG,
    OP_DIV_DG,
    OP_EMIT_RED,
    OP_EMIT_ONE
  } dp_op_t;

  // Sequencing condition selected by a control word.
  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_WAIT_IN,
    C_TRIVIAL,
    C_B_ZERO,
    C_DIV_BUSY,
    C_EMIT
  } cond_t;

  // One control word.
  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    upc_t   target;
  } ctrl_t;

  // Step addresses that are jump targets.
  localparam upc_t UPC_IDLE     = 4'd0;
  localparam upc_t UPC_CHECK    = 4'd1;
  localparam upc_t UPC_GCD_TEST = 4'd2;
  localparam upc_t UPC_GCD_DIV  = 4'd3;
  localparam upc_t UPC_GCD_NEXT = 4'd4;
  localparam upc_t UPC_DIV_N    = 4'd5;
  localparam upc_t UPC_DIV_N_LP = 4'd6;
  localparam upc_t UPC_DIV_D    = 4'd7;
  localparam upc_t UPC_DIV_D_LP = 4'd8;
  localparam upc_t UPC_EMIT_RED = 4'd9;
  localparam upc_t UPC_EMIT_ONE = 4'd10;

  // Control store. Self loops (waiting, dividing, output stall) are implied
  // by the condition; the target field serves the taken branches.
  function automatic ctrl_t ucode_rom(upc_t pc);
    ctrl_t w;
    unique case (pc)
      UPC_IDLE:     w = '{OP_LOAD,     C_WAIT_IN,  UPC_IDLE};
      UPC_CHECK:    w = '{OP_NOP,      C_TRIVIAL,  UPC_EMIT_ONE};
      UPC_GCD_TEST: w = '{OP_DIV_AB,   C_B_ZERO,   UPC_DIV_N};
      UPC_GCD_DIV:  w = '{OP_DIV_STEP, C_DIV_BUSY, UPC_GCD_DIV};
      UPC_GCD_NEXT: w = '{OP_SWAP,     C_JUMP,     UPC_GCD_TEST};
      UPC_DIV_N:    w = '{OP_DIV_NG,   C_NEXT,     UPC_IDLE};
      UPC_DIV_N_LP: w = '{OP_DIV_STEP, C_DIV_BUSY, UPC_DIV_N_LP};
      UPC_DIV_D:    w = '{OP_DIV_DG,   C_NEXT,     UPC_IDLE};
      UPC_DIV_D_LP: w = '{OP_DIV_STEP, C_DIV_BUSY, UPC_DIV_D_LP};
      UPC_EMIT_RED: w = '{OP_EMIT_RED, C_EMIT,     UPC_IDLE};
      UPC_EMIT_ONE: w = '{OP_EMIT_ONE, C_EMIT,     UPC_IDLE};
      default:      w = '{OP_NOP,      C_JUMP,     UPC_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ sv/frn_in_if.sv @@
// Input channel of the fraction ratio normalizer: one fraction per beat.
interface frn_in_if #(
  parameter int VALUE_WIDTH = 8
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] numerator;
  logic [VALUE_WIDTH-1:0] denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

@@ sv/frn_out_if.sv @@
// Result channel of the fraction ratio normalizer: one reduced fraction per beat.
interface frn_out_if #(
  parameter int VALUE_WIDTH = 8
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] reduced_numerator;
  logic [VALUE_WIDTH-1:0] reduced_denominator;
  logic                   changed;

  modport source (output valid, output reduced_numerator, output reduced_denominator,
                  output changed, input ready);
  modport sink   (input valid, input reduced_numerator, input reduced_denominator,
                  input changed, output ready);
endinterface

@@ sv/fraction_ratio_normalizer.sv @@
// Top level of the fraction ratio normalizer: microcoded Euclid GCD and reduction.
//
// Usage: a fraction numerator/denominator arrives as one beat on in_bus
// (valid/ready). If either value is zero or the numerator is not below the
// denominator, the result is 1/1; otherwise both values are divided by
// their greatest common divisor. One beat leaves on out_bus per input beat,
// carrying the reduced pair and a flag that is set when the pair changed.
// A small control store sequences one shared restoring divider that yields
// one quotient bit per cycle. Euclid remainder steps run on it first, then
// the two final divisions of numerator and denominator by the GCD. A clamped
// fraction skips all divisions and goes straight to its 1/1 emit step.
// One fraction is in work at a time. The result sits in an output
// register, so the next beat is taken while the previous result still
// waits. If the receiver stalls with a result still pending, the
// sequencer holds at its emit step until the register frees up. Reset
// returns the sequencer to its idle step and drops out valid; the input
// is not ready while reset is held.
module fraction_ratio_normalizer #(
  parameter int VALUE_WIDTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  frn_in_if.sink     in_bus,
  frn_out_if.source  out_bus
);
  import frn_pkg::*;

  localparam int CNT_W = $clog2(VALUE_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);
  localparam logic [VALUE_WIDTH-1:0] ONE = VALUE_WIDTH'(1);

  // Sequencer state.
  upc_t  pc_r;
  upc_t  pc_nxt;
  ctrl_t ctrl;

  // Datapath registers.
  logic [VALUE_WIDTH-1:0] n_r;
  logic [VALUE_WIDTH-1:0] d_r;
  logic [VALUE_WIDTH-1:0] a_r;
  logic [VALUE_WIDTH-1:0] b_r;
  logic [VALUE_WIDTH-1:0] q_r;
  logic [VALUE_WIDTH-1:0] rem_r;
  logic [VALUE_WIDTH-1:0] dv_r;
  logic [VALUE_WIDTH-1:0] rn_r;
  logic [CNT_W-1:0]       cnt_r;

  // Output register.
  logic                   out_valid_r;
  logic [VALUE_WIDTH-1:0] out_rn_r;
  logic [VALUE_WIDTH-1:0] out_rd_r;
  logic                   out_changed_r;

  // Decoded status.
  logic                   in_fire;
  logic                   out_free;
  logic                   emit_fire;
  logic                   trivial;
  logic [VALUE_WIDTH:0]   div_shift;
  logic [VALUE_WIDTH:0]   div_diff;
  logic                   div_bit;
  logic [VALUE_WIDTH-1:0] div_rem;

  // Control word fetch.
  always_comb begin
    ctrl = ucode_rom(pc_r);
  end

  assign in_bus.ready = rst_n && (ctrl.op == OP_LOAD);
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign out_free     = !out_valid_r || out_bus.ready;
  assign emit_fire    = out_free && (ctrl.op == OP_EMIT_RED || ctrl.op == OP_EMIT_ONE);
  assign trivial      = (n_r == '0) || (d_r == '0) || (n_r >= d_r);

  // One restoring division step: shift in the next dividend bit, try to subtract.
  always_comb begin
    div_shift = {rem_r, q_r[VALUE_WIDTH-1]};
    div_diff  = div_shift - {1'b0, dv_r};
    div_bit   = !div_diff[VALUE_WIDTH];
    div_rem   = div_bit ? div_diff[VALUE_WIDTH-1:0] : div_shift[VALUE_WIDTH-1:0];
  end

  // Next step address.
  always_comb begin
    unique case (ctrl.cond)
      C_NEXT:     pc_nxt = pc_r + upc_t'(1);
      C_JUMP:     pc_nxt = ctrl.target;
      C_WAIT_IN:  pc_nxt = in_bus.valid ? pc_r + upc_t'(1) : pc_r;
      C_TRIVIAL:  pc_nxt = trivial ? ctrl.target : pc_r + upc_t'(1);
      C_B_ZERO:   pc_nxt = (b_r == '0) ? ctrl.target : pc_r + upc_t'(1);
      C_DIV_BUSY: pc_nxt = (cnt_r != CNT_LAST) ? pc_r : pc_r + upc_t'(1);
      C_EMIT:     pc_nxt = out_free ? UPC_IDLE : pc_r;
      default:    pc_nxt = UPC_IDLE;
    endcase
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= UPC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // Datapath, driven by the operation field.
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_LOAD: begin
        if (in_fire) begin
          n_r <= in_bus.numerator;
          d_r <= in_bus.denominator;
          a_r <= in_bus.numerator;
          b_r <= in_bus.denominator;
        end
      end
      OP_DIV_AB: begin
        q_r   <= a_r;
        dv_r  <= b_r;
        rem_r <= '0;
        cnt_r <= '0;
      end
      OP_DIV_STEP: begin
        q_r   <= {q_r[VALUE_WIDTH-2:0], div_bit};
        rem_r <= div_rem;
        cnt_r <= cnt_r + CNT_W'(1);
      end
      OP_SWAP: begin
        a_r <= b_r;
        b_r <= rem_r;
      end
      OP_DIV_NG: begin
        q_r   <= n_r;
        dv_r  <= a_r;
        rem_r <= '0;
        cnt_r <= '0;
      end
      OP_DIV_DG: begin
        rn_r  <= q_r;
        q_r   <= d_r;
        dv_r  <= a_r;
        rem_r <= '0;
        cnt_r <= '0;
      end
      OP_NOP, OP_EMIT_RED, OP_EMIT_ONE: begin
      end
      default: begin
      end
    endcase
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (emit_fire) begin
      if (ctrl.op == OP_EMIT_ONE) begin
        out_rn_r      <= ONE;
        out_rd_r      <= ONE;
        out_changed_r <= (n_r != ONE) || (d_r != ONE);
      end else begin
        out_rn_r      <= rn_r;
        out_rd_r      <= q_r;
        out_changed_r <= (rn_r != n_r) || (q_r != d_r);
      end
    end
  end

  // Output valid: set on emit, cleared when the beat is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_bus.valid               = out_valid_r;
  assign out_bus.reduced_numerator   = out_rn_r;
  assign out_bus.reduced_denominator = out_rd_r;
  assign out_bus.changed             = out_changed_r;

endmodule
